[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and codes for the sorted timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FULL        = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_RUNNING     = 3'd3;
  localparam logic [2:0] ST_NOT_RUNNING = 3'd4;

  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [39:0] expiry;
    logic [39:0] start;
    logic [8:0]  ident;
    logic [31:0] period;
  } entry_t;

endpackage

[rtl/stt_ram.sv]
// ----------------------------------------------------------------------------
// stt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sorted_timer_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_timer_table_unit
// Timer table kept sorted by expiry in RAM; create, delete, tick and clear.
// ----------------------------------------------------------------------------
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_req_type .. in_now_sec
// out     | output    | out_valid, out_stall, out_status .. out_last
//
// Requests are handled one at a time by a sequencer over the entry RAM, each
// entry visited by a read state and its wait state: create and delete are a
// lookup plus a shift; a tick scans the expired prefix, then removes each fired
// timer, reinserts periodic ones, and gives one result per fired timer (one if none).
// Reset (synchronous) empties the table; RAM contents are not cleared.
// Results wait in an output register; the next request is taken meanwhile.
module sorted_timer_table_unit
  import stt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_interval,
  input  logic        in_loop_mode,
  input  logic [31:0] in_now_sec,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_fired,
  output logic [7:0]  out_fired_id,
  output logic        out_fired_periodic,
  output logic [4:0]  out_timer_count,
  output logic        out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = $bits(entry_t);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_FIND     = 5'd1;
  localparam logic [4:0] S_FIND_W   = 5'd2;
  localparam logic [4:0] S_EMIT1    = 5'd3;
  localparam logic [4:0] S_SHL      = 5'd4;
  localparam logic [4:0] S_SHL_W    = 5'd5;
  localparam logic [4:0] S_INS      = 5'd6;
  localparam logic [4:0] S_INS_W    = 5'd7;
  localparam logic [4:0] S_SHR      = 5'd8;
  localparam logic [4:0] S_SHR_W    = 5'd9;
  localparam logic [4:0] S_TSCAN    = 5'd10;
  localparam logic [4:0] S_TSCAN_W  = 5'd11;
  localparam logic [4:0] S_THEAD    = 5'd12;
  localparam logic [4:0] S_THEAD_W  = 5'd13;
  localparam logic [4:0] S_TREARM   = 5'd14;
  localparam logic [4:0] S_TREARM2  = 5'd15;
  localparam logic [4:0] S_TOUT     = 5'd16;
  localparam logic [4:0] S_TOUT_W   = 5'd17;

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] pre_r, pre_nxt;
  logic [CW-1:0] nf_r, nf_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [2:0]    st_r, st_nxt;

  logic [1:0]    req_r, req_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [31:0]   ivl_r, ivl_nxt;
  logic          loop_r, loop_nxt;
  logic [31:0]   now_r, now_nxt;
  entry_t        cur_r, cur_nxt;

  logic          ov_r, ov_nxt;
  logic [2:0]    os_r, os_nxt;
  logic          of_r, of_nxt;
  logic [7:0]    oid_r, oid_nxt;
  logic          op_r, op_nxt;
  logic [4:0]    oc_r, oc_nxt;
  logic          ol_r, ol_nxt;

  logic          m_we;
  logic [IW-1:0] m_waddr, m_raddr;
  entry_t        m_wdata, m_rdata;
  logic [EW-1:0] m_rraw;

  logic          f_we;
  logic [8:0]    f_rdata;

  logic          out_free;
  logic [32:0]   sum33;
  logic [40:0]   sum_s, sum_e;
  logic [39:0]   sat_s, sat_e;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !ov_r || !out_stall;
  assign m_rdata  = entry_t'(m_rraw);

  assign sum33 = {1'b0, now_r} + {1'b0, ivl_r};
  assign sum_s = {1'b0, cur_r.start} + {9'd0, cur_r.period};
  assign sat_s = sum_s[40] ? MAX40 : sum_s[39:0];
  assign sum_e = {1'b0, cur_r.start} + {9'd0, cur_r.period};
  assign sat_e = sum_e[40] ? MAX40 : sum_e[39:0];

  stt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_tab (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rraw)
  );

  stt_ram #(.WIDTH(9), .DEPTH(SLOTS)) u_fired (
    .clk   (clk),
    .we    (f_we),
    .waddr (nf_r[IW-1:0]),
    .wdata (m_rdata.ident),
    .raddr (j_r[IW-1:0]),
    .rdata (f_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    pos_nxt   = pos_r;
    pre_nxt   = pre_r;
    nf_nxt    = nf_r;
    j_nxt     = j_r;
    st_nxt    = st_r;
    req_nxt   = req_r;
    id_nxt    = id_r;
    ivl_nxt   = ivl_r;
    loop_nxt  = loop_r;
    now_nxt   = now_r;
    cur_nxt   = cur_r;
    ov_nxt    = ov_r && out_stall;
    os_nxt    = os_r;
    of_nxt    = of_r;
    oid_nxt   = oid_r;
    op_nxt    = op_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    m_we      = 1'b0;
    m_waddr   = i_r[IW-1:0];
    m_wdata   = m_rdata;
    m_raddr   = i_r[IW-1:0];
    f_we      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_req_type;
          id_nxt   = in_timer_id;
          ivl_nxt  = in_interval;
          loop_nxt = in_loop_mode;
          now_nxt  = in_now_sec;
          i_nxt    = '0;
          st_nxt   = ST_OK;
          case (in_req_type)
            REQ_CREATE, REQ_DELETE: state_nxt = S_FIND;
            REQ_TICK:               state_nxt = S_TSCAN;
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_EMIT1;
            end
          endcase
        end
      end

      S_FIND: begin
        if (i_r == cnt_r) begin
          if (req_r == REQ_DELETE) begin
            st_nxt    = ST_NOT_RUNNING;
            state_nxt = S_EMIT1;
          end else if (cnt_r == CW'(SLOTS)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_EMIT1;
          end else if (sum33[32]) begin
            st_nxt    = ST_OVERFLOW;
            state_nxt = S_EMIT1;
          end else begin
            cur_nxt.expiry = {8'd0, sum33[31:0]};
            cur_nxt.start  = {8'd0, now_r};
            cur_nxt.ident  = {loop_r, id_r};
            cur_nxt.period = ivl_r;
            i_nxt          = '0;
            state_nxt      = S_INS;
          end
        end else begin
          state_nxt = S_FIND_W;
        end
      end

      S_FIND_W: begin
        if (m_rdata.ident[7:0] == id_r) begin
          if (req_r == REQ_DELETE) begin
            pos_nxt   = i_r;
            state_nxt = S_SHL;
          end else begin
            st_nxt    = ST_RUNNING;
            state_nxt = S_EMIT1;
          end
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_FIND;
        end
      end

      S_EMIT1: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          os_nxt    = st_r;
          of_nxt    = 1'b0;
          oid_nxt   = 8'd0;
          op_nxt    = 1'b0;
          oc_nxt    = 5'(cnt_r);
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SHL: begin
        m_raddr = IW'(pos_r + CW'(1));
        if (({1'b0, pos_r} + (CW+1)'(1)) < {1'b0, cnt_r}) begin
          state_nxt = S_SHL_W;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = (req_r == REQ_TICK) ? S_TREARM : S_EMIT1;
        end
      end

      S_SHL_W: begin
        m_we      = 1'b1;
        m_waddr   = pos_r[IW-1:0];
        pos_nxt   = pos_r + CW'(1);
        state_nxt = S_SHL;
      end

      S_INS: begin
        if (i_r == cnt_r) begin
          pos_nxt   = i_r;
          state_nxt = S_SHR;
        end else begin
          state_nxt = S_INS_W;
        end
      end

      S_INS_W: begin
        if (m_rdata.expiry <= cur_r.expiry) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_INS;
        end else begin
          pos_nxt   = i_r;
          i_nxt     = cnt_r;
          state_nxt = S_SHR;
        end
      end

      S_SHR: begin
        m_raddr = IW'(i_r - CW'(1));
        if (i_r > pos_r) begin
          state_nxt = S_SHR_W;
        end else begin
          m_we      = 1'b1;
          m_waddr   = pos_r[IW-1:0];
          m_wdata   = cur_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = (req_r == REQ_TICK) ? S_THEAD : S_EMIT1;
        end
      end

      S_SHR_W: begin
        m_we      = 1'b1;
        m_waddr   = i_r[IW-1:0];
        i_nxt     = i_r - CW'(1);
        state_nxt = S_SHR;
      end

      S_TSCAN: begin
        if (i_r == cnt_r) begin
          pre_nxt   = i_r;
          nf_nxt    = '0;
          state_nxt = (i_r == '0) ? S_EMIT1 : S_THEAD;
        end else begin
          state_nxt = S_TSCAN_W;
        end
      end

      S_TSCAN_W: begin
        if (m_rdata.expiry <= {8'd0, now_r}) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_TSCAN;
        end else begin
          pre_nxt   = i_r;
          nf_nxt    = '0;
          state_nxt = (i_r == '0) ? S_EMIT1 : S_THEAD;
        end
      end

      S_THEAD: begin
        m_raddr = '0;
        if (pre_r == '0) begin
          j_nxt     = '0;
          state_nxt = S_TOUT;
        end else begin
          state_nxt = S_THEAD_W;
        end
      end

      S_THEAD_W: begin
        cur_nxt   = m_rdata;
        f_we      = 1'b1;
        nf_nxt    = nf_r + CW'(1);
        pre_nxt   = pre_r - CW'(1);
        pos_nxt   = '0;
        state_nxt = S_SHL;
      end

      S_TREARM: begin
        if (cur_r.ident[8]) begin
          cur_nxt.start = sat_s;
          state_nxt     = S_TREARM2;
        end else begin
          state_nxt = S_THEAD;
        end
      end

      S_TREARM2: begin
        cur_nxt.expiry = sat_e;
        i_nxt          = pre_r;
        state_nxt      = S_INS;
      end

      S_TOUT: begin
        state_nxt = S_TOUT_W;
      end

      S_TOUT_W: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          os_nxt  = ST_OK;
          of_nxt  = 1'b1;
          oid_nxt = f_rdata[7:0];
          op_nxt  = f_rdata[8];
          oc_nxt  = 5'(cnt_r);
          ol_nxt  = ((j_r + CW'(1)) == nf_r);
          j_nxt   = j_r + CW'(1);
          state_nxt = ((j_r + CW'(1)) == nf_r) ? S_IDLE : S_TOUT;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    i_r    <= i_nxt;
    pos_r  <= pos_nxt;
    pre_r  <= pre_nxt;
    nf_r   <= nf_nxt;
    j_r    <= j_nxt;
    st_r   <= st_nxt;
    req_r  <= req_nxt;
    id_r   <= id_nxt;
    ivl_r  <= ivl_nxt;
    loop_r <= loop_nxt;
    now_r  <= now_nxt;
    cur_r  <= cur_nxt;
    os_r   <= os_nxt;
    of_r   <= of_nxt;
    oid_r  <= oid_nxt;
    op_r   <= op_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_fired          = of_r;
  assign out_fired_id       = oid_r;
  assign out_fired_periodic = op_r;
  assign out_timer_count    = oc_r;
  assign out_last           = ol_r;

endmodule
